// ===== sv/psd_pkg.sv =====
// Shared widths, region codes and pipeline tag type for the point-segment distance block.
package psd_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 2;
  localparam int XW  = PW + 1;
  localparam int XLO = (XW + 1) / 2;
  localparam int XHI = XW - XLO;
  localparam int CCW = 2 * XW;
  localparam int LW  = PW;
  localparam int QW  = SW;
  localparam int RW  = QW / 2;
  localparam int OW  = 32;

  typedef enum logic [1:0] {
    REGION_START  = 2'd0,
    REGION_END    = 2'd1,
    REGION_INSIDE = 2'd2
  } region_t;

  typedef struct packed {
    logic    vld;
    region_t region;
  } psd_tag_t;

endpackage

// ===== sv/psd_if.sv =====
// Valid/ready channel interfaces for query words and distance words.
interface psd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [psd_pkg::COORD_WIDTH-1:0] point_x;
  logic signed [psd_pkg::COORD_WIDTH-1:0] point_y;
  logic signed [psd_pkg::COORD_WIDTH-1:0] point_z;
  logic signed [psd_pkg::COORD_WIDTH-1:0] start_x;
  logic signed [psd_pkg::COORD_WIDTH-1:0] start_y;
  logic signed [psd_pkg::COORD_WIDTH-1:0] start_z;
  logic signed [psd_pkg::COORD_WIDTH-1:0] end_x;
  logic signed [psd_pkg::COORD_WIDTH-1:0] end_y;
  logic signed [psd_pkg::COORD_WIDTH-1:0] end_z;

  modport source (output valid, point_x, point_y, point_z, start_x, start_y, start_z,
                  end_x, end_y, end_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, start_x, start_y, start_z,
                end_x, end_y, end_z, output ready);
endinterface

interface psd_out_if;
  logic                        valid;
  logic                        ready;
  logic [psd_pkg::OW-1:0]      distance;
  logic                        saturated;
  logic [1:0]                  nearest_region;

  modport source (output valid, distance, saturated, nearest_region, input ready);
  modport sink (input valid, distance, saturated, nearest_region, output ready);
endinterface

// ===== sv/point_segment_distance_3d.sv =====
// Top level: point to segment distance pipeline with output register.
//
//   channel   dir  word
//   in_chan   in   point, start and end coordinates (signed, 32 bits each)
//   out_chan  out  distance, saturated flag, nearest region
//
// One word enters per cycle while the output is not stalled.
// Most of the depth is in the divider (one quotient bit per stage) and the root
// (one root bit per stage). Reset clears only the valid bits.
// A stall at the output holds every stage; nothing is lost or repeated.
module point_segment_distance_3d (
  input  logic          clk,
  input  logic          rst_n,
  psd_in_if.sink        in_chan,
  psd_out_if.source     out_chan
);

  logic                       en;
  logic signed [psd_pkg::COORD_WIDTH-1:0] p [3];
  logic signed [psd_pkg::COORD_WIDTH-1:0] a [3];
  logic signed [psd_pkg::COORD_WIDTH-1:0] b [3];
  psd_pkg::psd_tag_t          tag_f;
  psd_pkg::psd_tag_t          tag_d;
  psd_pkg::psd_tag_t          tag_s;
  logic [psd_pkg::CCW-1:0]    dividend;
  logic [psd_pkg::LW-1:0]     divisor;
  logic [psd_pkg::QW-1:0]     quot;
  logic [psd_pkg::RW-1:0]     root;
  logic                       sat;

  logic                       out_valid_r;
  logic [psd_pkg::OW-1:0]     distance_r;
  logic                       saturated_r;
  psd_pkg::region_t           region_r;

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  assign p[0] = in_chan.point_x;
  assign p[1] = in_chan.point_y;
  assign p[2] = in_chan.point_z;
  assign a[0] = in_chan.start_x;
  assign a[1] = in_chan.start_y;
  assign a[2] = in_chan.start_z;
  assign b[0] = in_chan.end_x;
  assign b[1] = in_chan.end_y;
  assign b[2] = in_chan.end_z;

  psd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_chan.valid),
    .p          (p),
    .a          (a),
    .b          (b),
    .tag_o      (tag_f),
    .dividend_o (dividend),
    .divisor_o  (divisor)
  );

  psd_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .tag_i      (tag_f),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .tag_o      (tag_d),
    .quot_o     (quot)
  );

  psd_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_i  (tag_d),
    .rad_i  (quot),
    .tag_o  (tag_s),
    .root_o (root)
  );

  assign sat = |root[psd_pkg::RW-1:psd_pkg::OW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag_s.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distance_r  <= sat ? '1 : root[psd_pkg::OW-1:0];
      saturated_r <= sat;
      region_r    <= tag_s.region;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.distance       = distance_r;
  assign out_chan.saturated      = saturated_r;
  assign out_chan.nearest_region = region_r;

endmodule

// ===== sv/psd_front.sv =====
// Front pipeline: differences, products, dot and cross sums, region pick, cross squares, divider operand pick.
module psd_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_vld,
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] p [3],
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] a [3],
  input  logic signed [psd_pkg::COORD_WIDTH-1:0] b [3],
  output psd_pkg::psd_tag_t                      tag_o,
  output logic [psd_pkg::CCW-1:0]                dividend_o,
  output logic [psd_pkg::LW-1:0]                 divisor_o
);

  logic signed [psd_pkg::DW-1:0]  s_r [3];
  logic signed [psd_pkg::DW-1:0]  w_r [3];
  logic signed [psd_pkg::DW-1:0]  v_r [3];
  logic signed [psd_pkg::PW-1:0]  sw_r [3];
  logic signed [psd_pkg::PW-1:0]  ss_r [3];
  logic signed [psd_pkg::PW-1:0]  ww_r [3];
  logic signed [psd_pkg::PW-1:0]  vv_r [3];
  logic signed [psd_pkg::PW-1:0]  xp_r [6];
  logic signed [psd_pkg::SW-1:0]  proj_r;
  logic [psd_pkg::LW-1:0]         len2_r;
  logic [psd_pkg::SW-1:0]         wsum_r;
  logic [psd_pkg::SW-1:0]         vsum_r;
  logic signed [psd_pkg::XW-1:0]  c_r [3];
  psd_pkg::region_t               region4_r;
  logic [psd_pkg::SW-1:0]         dend4_r;
  logic [psd_pkg::LW-1:0]         len4_r;
  logic [2*psd_pkg::XHI-1:0]      hh_r [3];
  logic [psd_pkg::XW-1:0]         lh_r [3];
  logic [2*psd_pkg::XLO-1:0]      ll_r [3];
  psd_pkg::region_t               region5_r;
  logic [psd_pkg::SW-1:0]         dend5_r;
  logic [psd_pkg::LW-1:0]         len5_r;
  logic [psd_pkg::CCW-1:0]        csq_r [3];
  logic [5:0]                     vld_r;
  psd_pkg::region_t               region6_r;
  logic [psd_pkg::CCW-1:0]        dividend_r;
  logic [psd_pkg::LW-1:0]         divisor_r;

  psd_pkg::region_t               region_nxt;
  logic [psd_pkg::XW-1:0]         cm [3];
  logic [psd_pkg::CCW-1:0]        ccsum;
  logic                           pos;

  always_comb begin
    pos = !proj_r[psd_pkg::SW-1] && (proj_r != '0) && (len2_r != '0);
    if (pos && ($unsigned(proj_r) >= psd_pkg::SW'(len2_r))) begin
      region_nxt = psd_pkg::REGION_END;
    end else if (pos) begin
      region_nxt = psd_pkg::REGION_INSIDE;
    end else begin
      region_nxt = psd_pkg::REGION_START;
    end
    for (int i = 0; i < 3; i++) begin
      cm[i] = c_r[i][psd_pkg::XW-1] ? $unsigned(-c_r[i]) : $unsigned(c_r[i]);
    end
    ccsum = csq_r[0] + csq_r[1] + csq_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i]  <= psd_pkg::DW'(b[i]) - psd_pkg::DW'(a[i]);
        w_r[i]  <= psd_pkg::DW'(p[i]) - psd_pkg::DW'(a[i]);
        v_r[i]  <= psd_pkg::DW'(p[i]) - psd_pkg::DW'(b[i]);
        sw_r[i] <= s_r[i] * w_r[i];
        ss_r[i] <= s_r[i] * s_r[i];
        ww_r[i] <= w_r[i] * w_r[i];
        vv_r[i] <= v_r[i] * v_r[i];
      end
      xp_r[0] <= s_r[1] * w_r[2];
      xp_r[1] <= s_r[2] * w_r[1];
      xp_r[2] <= s_r[2] * w_r[0];
      xp_r[3] <= s_r[0] * w_r[2];
      xp_r[4] <= s_r[0] * w_r[1];
      xp_r[5] <= s_r[1] * w_r[0];
      proj_r <= psd_pkg::SW'(sw_r[0]) + psd_pkg::SW'(sw_r[1]) + psd_pkg::SW'(sw_r[2]);
      len2_r <= $unsigned(ss_r[0]) + $unsigned(ss_r[1]) + $unsigned(ss_r[2]);
      wsum_r <= psd_pkg::SW'($unsigned(ww_r[0])) + psd_pkg::SW'($unsigned(ww_r[1]))
              + psd_pkg::SW'($unsigned(ww_r[2]));
      vsum_r <= psd_pkg::SW'($unsigned(vv_r[0])) + psd_pkg::SW'($unsigned(vv_r[1]))
              + psd_pkg::SW'($unsigned(vv_r[2]));
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= psd_pkg::XW'(xp_r[2*i]) - psd_pkg::XW'(xp_r[2*i+1]);
      end
      region4_r <= region_nxt;
      dend4_r   <= (region_nxt == psd_pkg::REGION_END) ? vsum_r : wsum_r;
      len4_r    <= len2_r;
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= cm[i][psd_pkg::XW-1:psd_pkg::XLO] * cm[i][psd_pkg::XW-1:psd_pkg::XLO];
        lh_r[i] <= cm[i][psd_pkg::XW-1:psd_pkg::XLO] * cm[i][psd_pkg::XLO-1:0];
        ll_r[i] <= cm[i][psd_pkg::XLO-1:0] * cm[i][psd_pkg::XLO-1:0];
      end
      region5_r <= region4_r;
      dend5_r   <= dend4_r;
      len5_r    <= len4_r;
      for (int i = 0; i < 3; i++) begin
        csq_r[i] <= (psd_pkg::CCW'(hh_r[i]) << (2*psd_pkg::XLO))
                  + (psd_pkg::CCW'(lh_r[i]) << (psd_pkg::XLO+1))
                  + psd_pkg::CCW'(ll_r[i]);
      end
      region6_r <= region5_r;
      if (region5_r == psd_pkg::REGION_INSIDE) begin
        dividend_r <= ccsum;
        divisor_r  <= len5_r;
      end else begin
        dividend_r <= psd_pkg::CCW'(dend5_r);
        divisor_r  <= psd_pkg::LW'(1);
      end
    end
  end

  assign tag_o.vld    = vld_r[5];
  assign tag_o.region = region6_r;
  assign dividend_o   = dividend_r;
  assign divisor_o    = divisor_r;

endmodule

// ===== sv/psd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module psd_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  psd_pkg::psd_tag_t       tag_i,
  input  logic [psd_pkg::CCW-1:0] dividend_i,
  input  logic [psd_pkg::LW-1:0]  divisor_i,
  output psd_pkg::psd_tag_t       tag_o,
  output logic [psd_pkg::QW-1:0]  quot_o
);

  logic [psd_pkg::LW-1:0]  rem_r [psd_pkg::QW+1];
  logic [psd_pkg::QW-1:0]  x_r   [psd_pkg::QW+1];
  logic [psd_pkg::LW-1:0]  dv_r  [psd_pkg::QW+1];
  psd_pkg::region_t        rg_r  [psd_pkg::QW+1];
  logic [psd_pkg::QW:0]    vld_r;

  logic [psd_pkg::LW-1:0]  rem_nxt [psd_pkg::QW];
  logic                    qb      [psd_pkg::QW];
  logic [psd_pkg::LW:0]    t       [psd_pkg::QW];

  always_comb begin
    for (int k = 0; k < psd_pkg::QW; k++) begin
      t[k]  = {rem_r[k], x_r[k][psd_pkg::QW-1]};
      qb[k] = t[k] >= {1'b0, dv_r[k]};
      rem_nxt[k] = qb[k] ? psd_pkg::LW'(t[k] - {1'b0, dv_r[k]}) : psd_pkg::LW'(t[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[psd_pkg::QW-1:0], tag_i.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= dividend_i[psd_pkg::CCW-1:psd_pkg::QW];
      x_r[0]   <= dividend_i[psd_pkg::QW-1:0];
      dv_r[0]  <= divisor_i;
      rg_r[0]  <= tag_i.region;
      for (int k = 0; k < psd_pkg::QW; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        x_r[k+1]   <= {x_r[k][psd_pkg::QW-2:0], qb[k]};
        dv_r[k+1]  <= dv_r[k];
        rg_r[k+1]  <= rg_r[k];
      end
    end
  end

  assign tag_o.vld    = vld_r[psd_pkg::QW];
  assign tag_o.region = rg_r[psd_pkg::QW];
  assign quot_o       = x_r[psd_pkg::QW];

endmodule

// ===== sv/psd_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module psd_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  psd_pkg::psd_tag_t      tag_i,
  input  logic [psd_pkg::QW-1:0] rad_i,
  output psd_pkg::psd_tag_t      tag_o,
  output logic [psd_pkg::RW-1:0] root_o
);

  logic [psd_pkg::RW+1:0]  rem_r  [psd_pkg::RW+1];
  logic [psd_pkg::RW-1:0]  root_r [psd_pkg::RW+1];
  logic [psd_pkg::QW-1:0]  x_r    [psd_pkg::RW+1];
  psd_pkg::region_t        rg_r   [psd_pkg::RW+1];
  logic [psd_pkg::RW:0]    vld_r;

  logic [psd_pkg::RW+3:0]  r2    [psd_pkg::RW];
  logic [psd_pkg::RW+3:0]  trial [psd_pkg::RW];
  logic                    ge    [psd_pkg::RW];

  always_comb begin
    for (int k = 0; k < psd_pkg::RW; k++) begin
      r2[k]    = {rem_r[k], x_r[k][psd_pkg::QW-1:psd_pkg::QW-2]};
      trial[k] = {2'b00, root_r[k], 2'b01};
      ge[k]    = r2[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[psd_pkg::RW-1:0], tag_i.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      x_r[0]    <= rad_i;
      rg_r[0]   <= tag_i.region;
      for (int k = 0; k < psd_pkg::RW; k++) begin
        rem_r[k+1]  <= ge[k] ? (psd_pkg::RW+2)'(r2[k] - trial[k])
                             : (psd_pkg::RW+2)'(r2[k]);
        root_r[k+1] <= {root_r[k][psd_pkg::RW-2:0], ge[k]};
        x_r[k+1]    <= {x_r[k][psd_pkg::QW-3:0], 2'b00};
        rg_r[k+1]   <= rg_r[k];
      end
    end
  end

  assign tag_o.vld    = vld_r[psd_pkg::RW];
  assign tag_o.region = rg_r[psd_pkg::RW];
  assign root_o       = root_r[psd_pkg::RW];

endmodule
